>>> hw/rtl/slbm_pkg.sv
// Shared types and constants of the serial loaded bank mapper.
`default_nettype none

package slbm_pkg;

   localparam int PRG_ADDR_BITS_DEFAULT = 18;
   localparam int PRG_CALC_BITS         = 19;

   localparam int REQ_TDATA_BITS = 24;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 32;
   localparam int RSP_TUSER_BITS = 3;
   localparam int MAP_ADDR_BITS  = 18;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [4:0] MODE_RESET      = 5'h0C;
   localparam logic [2:0] LOADER_LAST     = 3'd4;
   localparam logic [2:0] RAM_WINDOW      = 3'b011;
   localparam logic [2:0] CHR_WINDOW      = 3'b000;
   localparam logic [4:0] PRG_BANKS_RESET = 5'd2;
   localparam logic [12:0] RAM_MASK_RESET = 13'h1FFF;

   typedef enum logic [1:0] {
      OP_CPU_READ  = 2'd0,
      OP_CPU_WRITE = 2'd1,
      OP_PPU_READ  = 2'd2,
      OP_PPU_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TGT_NONE    = 2'd0,
      TGT_PRG_ROM = 2'd1,
      TGT_PRG_RAM = 2'd2,
      TGT_CHR     = 2'd3
   } target_type;

   typedef enum logic [1:0] {
      SEL_CONTROL  = 2'd0,
      SEL_CHR_LOW  = 2'd1,
      SEL_CHR_HIGH = 2'd2,
      SEL_PRG      = 2'd3
   } reg_sel_type;

   typedef enum logic [1:0] {
      CSR_PRG_ROM_BANKS = 2'd0,
      CSR_PRG_RAM_MASK  = 2'd1,
      CSR_CHR_IS_RAM    = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      PRG_MODE_FIX_FIRST = 2'd2,
      PRG_MODE_FIX_LAST  = 2'd3
   } prg_mode_type;

   typedef struct packed {
      logic        strobe;
      logic        clear;
      logic        bit_in;
      reg_sel_type sel;
   } loader_cmd_type;

   typedef struct packed {
      logic [4:0] control;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic [4:0] prg_bank;
   } bank_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/serial_loaded_bank_mapper_unit.sv
// Path: a beat accepted into the input register moves on to the result register,
// which drives rsp_tvalid.
// Throughput: one beat per cycle; req_tready drops only while both registers hold
// a beat and rsp_tready is low.
// Reset: synchronous, active high; clears both valid bits and the serial loader,
// loads control with PRG mode three and returns the configuration to its defaults.
`default_nettype none

module serial_loaded_bank_mapper_unit
   import slbm_pkg::*;
#(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // bus_address [15:0], write_data [23:16]
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   // operation [1:0]
   input  wire logic [REQ_TUSER_BITS-1:0] req_tuser,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   // mapped_address [17:0], data_out [25:18], zero [31:26]
   output      logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // target [1:0], write_enable [2]
   output      logic [RSP_TUSER_BITS-1:0] rsp_tuser,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output      logic                      csr_pready
);

   localparam logic [PRG_CALC_BITS-1:0] PrgMask =
      PRG_CALC_BITS'((64'd1 << PRG_ADDR_BITS) - 64'd1);

   logic [4:0]  prg_rom_banks_ff;
   logic [12:0] prg_ram_mask_ff;
   logic        chr_is_ram_ff;
   logic        csr_write;
   csr_idx_type csr_idx;

   logic        s1_valid_ff;
   op_type      s1_op_ff;
   logic [15:0] s1_addr_ff;
   logic [7:0]  s1_data_ff;

   logic                     rsp_valid_ff;
   target_type               rsp_target_ff, rsp_target_in;
   logic [MAP_ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic                     rsp_we_ff, rsp_we_in;
   logic [7:0]               rsp_dout_ff, rsp_dout_in;

   logic               advance;
   logic               loader_hit;
   loader_cmd_type     cmd;
   bank_state_type     banks;
   logic [4:0]         prg_page;
   logic [PRG_CALC_BITS-1:0] prg_full;
   logic [4:0]         chr_bank;
   prg_mode_type       prg_mode;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_rom_banks_ff <= PRG_BANKS_RESET;
         prg_ram_mask_ff  <= RAM_MASK_RESET;
         chr_is_ram_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_PRG_ROM_BANKS: prg_rom_banks_ff <= csr_pwdata[4:0];
            CSR_PRG_RAM_MASK:  prg_ram_mask_ff  <= csr_pwdata[12:0];
            CSR_CHR_IS_RAM:    chr_is_ram_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_PRG_ROM_BANKS: csr_prdata = {27'd0, prg_rom_banks_ff};
         CSR_PRG_RAM_MASK:  csr_prdata = {19'd0, prg_ram_mask_ff};
         CSR_CHR_IS_RAM:    csr_prdata = {31'd0, chr_is_ram_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // pipeline handshake
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance | ~s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff   <= op_type'(req_tuser);
         s1_addr_ff <= req_tdata[15:0];
         s1_data_ff <= req_tdata[23:16];
      end
   end

   // PRG ROM page select
   assign prg_mode = prg_mode_type'(banks.control[3:2]);

   always_comb begin
      if (!banks.control[3]) begin
         prg_page = {1'b0, banks.prg_bank[3:1], s1_addr_ff[14]};
      end else if (prg_mode == PRG_MODE_FIX_FIRST) begin
         prg_page = s1_addr_ff[14] ? {1'b0, banks.prg_bank[3:0]} : 5'd0;
      end else begin
         prg_page = s1_addr_ff[14] ? prg_rom_banks_ff - 5'd1
                                   : {1'b0, banks.prg_bank[3:0]};
      end
      prg_full = {prg_page, s1_addr_ff[13:0]} & PrgMask;
   end

   // CHR bank select
   always_comb begin
      if (!banks.control[4]) begin
         chr_bank = {banks.chr_low[4:1], s1_addr_ff[12]};
      end else begin
         chr_bank = s1_addr_ff[12] ? banks.chr_high : banks.chr_low;
      end
   end

   // translate
   always_comb begin
      rsp_target_in = TGT_NONE;
      rsp_addr_in   = '0;
      rsp_we_in     = 1'b0;
      rsp_dout_in   = '0;
      loader_hit    = 1'b0;
      if (s1_op_ff == OP_CPU_READ || s1_op_ff == OP_CPU_WRITE) begin
         if (s1_addr_ff[15:13] == RAM_WINDOW) begin
            rsp_target_in = TGT_PRG_RAM;
            rsp_addr_in   = {5'd0, s1_addr_ff[12:0] & prg_ram_mask_ff};
            if (s1_op_ff == OP_CPU_WRITE) begin
               rsp_we_in   = 1'b1;
               rsp_dout_in = s1_data_ff;
            end
         end else if (s1_addr_ff[15]) begin
            if (s1_op_ff == OP_CPU_READ) begin
               rsp_target_in = TGT_PRG_ROM;
               rsp_addr_in   = prg_full[MAP_ADDR_BITS-1:0];
            end else begin
               loader_hit = 1'b1;
            end
         end
      end else if (s1_addr_ff[15:13] == CHR_WINDOW) begin
         rsp_target_in = TGT_CHR;
         rsp_addr_in   = {1'b0, chr_bank, s1_addr_ff[11:0]};
         if (s1_op_ff == OP_PPU_WRITE && chr_is_ram_ff) begin
            rsp_we_in   = 1'b1;
            rsp_dout_in = s1_data_ff;
         end
      end
   end

   assign cmd.strobe = loader_hit & s1_valid_ff & advance;
   assign cmd.clear  = s1_data_ff[7];
   assign cmd.bit_in = s1_data_ff[0];
   assign cmd.sel    = reg_sel_type'(s1_addr_ff[14:13]);

   slbm_loader u_loader (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .banks (banks)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_target_ff <= rsp_target_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_we_ff     <= rsp_we_in;
         rsp_dout_ff   <= rsp_dout_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_dout_ff, rsp_addr_ff};
   assign rsp_tuser  = {rsp_we_ff, rsp_target_ff};

endmodule

`default_nettype wire

>>> hw/rtl/slbm_loader.sv
// Serial loader and the control, CHR and PRG bank registers.
`default_nettype none

module slbm_loader
   import slbm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire loader_cmd_type cmd,
   output bank_state_type     banks
);

   logic [4:0]     bits_ff, bits_in;
   logic [2:0]     count_ff, count_in;
   bank_state_type banks_ff, banks_in;
   logic [4:0]     shifted;

   always_comb begin
      bits_in  = bits_ff;
      count_in = count_ff;
      banks_in = banks_ff;
      shifted  = {cmd.bit_in, bits_ff[4:1]};
      if (cmd.strobe) begin
         if (cmd.clear) begin
            bits_in          = '0;
            count_in         = '0;
            banks_in.control = banks_ff.control | MODE_RESET;
         end else if (count_ff == LOADER_LAST) begin
            bits_in  = '0;
            count_in = '0;
            unique case (cmd.sel)
               SEL_CONTROL:  banks_in.control  = shifted;
               SEL_CHR_LOW:  banks_in.chr_low  = shifted;
               SEL_CHR_HIGH: banks_in.chr_high = shifted;
               SEL_PRG:      banks_in.prg_bank = shifted;
               default:      banks_in.prg_bank = shifted;
            endcase
         end else begin
            bits_in  = shifted;
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff           <= '0;
         count_ff          <= '0;
         banks_ff.control  <= MODE_RESET;
         banks_ff.chr_low  <= '0;
         banks_ff.chr_high <= '0;
         banks_ff.prg_bank <= '0;
      end else begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         banks_ff <= banks_in;
      end
   end

   assign banks = banks_ff;

endmodule

`default_nettype wire

>>> hw/rtl/slbm_checker.sv
// Port-level checks of the bank mapper and their bind to the top level.
`default_nettype none

module slbm_checker
   import slbm_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_BITS-1:0] rsp_tuser,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat valid right after reset");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == TGT_NONE |-> rsp_tdata[17:0] == 18'd0)
      else $error("unmapped beat carries an address");

   a_read_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata[31:18] == 14'd0)
      else $error("beat without write strobe carries data");

   a_we_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         rsp_tuser[1:0] == TGT_PRG_RAM || rsp_tuser[1:0] == TGT_CHR)
      else $error("write strobe on a read-only target");

endmodule

bind serial_loaded_bank_mapper_unit slbm_checker u_slbm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

>>> bench/serial_loaded_bank_mapper_unit_tb.sv
// Self-checks the serial loaded bank mapper: directed and random accesses against a predictor.
`default_nettype none

module serial_loaded_bank_mapper_unit_tb
   import slbm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRG_BITS     = PRG_ADDR_BITS_DEFAULT;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEGMENT_LEN  = 280;

   typedef struct {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_access_type;

   typedef struct {
      target_type  tgt;
      logic [17:0] offset;
      logic        we;
      logic [7:0]  wdata;
   } mapped_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_TUSER_BITS-1:0] req_tuser  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   serial_loaded_bank_mapper_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of configuration and mapper state
   logic [4:0]  cfg_prg_banks = PRG_BANKS_RESET;
   logic [12:0] cfg_ram_mask  = RAM_MASK_RESET;
   logic        cfg_chr_ram   = 1'b0;
   logic [4:0]  ldr_bits      = '0;
   logic [2:0]  ldr_count     = '0;
   logic [4:0]  ctrl_mode     = MODE_RESET;
   logic [4:0]  chr_lo        = '0;
   logic [4:0]  chr_hi        = '0;
   logic [4:0]  prg_sel       = '0;

   bus_access_type  access_queue[$];
   mapped_beat_type expected_maps[$];
   int  pushed_count   = 0;
   int  accepted_count = 0;
   int  error_count    = 0;
   int  cycle_count    = 0;
   int  send_idle_pct  = 21;
   int  recv_stall_pct = 77;
   logic req_fire      = 1'b0;

   function automatic logic [17:0] prg_offset(logic [15:0] a);
      logic [31:0] bank;
      logic [31:0] off;
      logic [31:0] res;
      bank = {28'd0, prg_sel[3:0]};
      off  = {18'd0, a[13:0]};
      if (ctrl_mode[3:2] < PRG_MODE_FIX_FIRST) begin
         res = (bank >> 1) * 32'h8000 + {17'd0, a[14:0]};
      end else if (ctrl_mode[3:2] == PRG_MODE_FIX_FIRST) begin
         res = a[14] ? bank * 32'h4000 + off : off;
      end else begin
         res = a[14] ? ({27'd0, cfg_prg_banks} - 32'd1) * 32'h4000 + off
                     : bank * 32'h4000 + off;
      end
      return 18'(res & ((32'd1 << PRG_BITS) - 32'd1));
   endfunction

   function automatic void feed_loader(logic [15:0] a, logic [7:0] d);
      logic [4:0] shifted;
      shifted = {d[0], ldr_bits[4:1]};
      if (d[7]) begin
         ldr_bits  = '0;
         ldr_count = '0;
         ctrl_mode = ctrl_mode | MODE_RESET;
      end else if (ldr_count == LOADER_LAST) begin
         case (reg_sel_type'(a[14:13]))
            SEL_CONTROL:  ctrl_mode = shifted;
            SEL_CHR_LOW:  chr_lo    = shifted;
            SEL_CHR_HIGH: chr_hi    = shifted;
            default:      prg_sel   = shifted;
         endcase
         ldr_bits  = '0;
         ldr_count = '0;
      end else begin
         ldr_bits  = shifted;
         ldr_count = ldr_count + 3'd1;
      end
   endfunction

   function automatic mapped_beat_type map_access(bus_access_type acc);
      mapped_beat_type r;
      logic [4:0]      bank;
      r.tgt    = TGT_NONE;
      r.offset = '0;
      r.we     = 1'b0;
      r.wdata  = '0;
      if (acc.op == OP_CPU_READ || acc.op == OP_CPU_WRITE) begin
         if (acc.addr[15:13] == RAM_WINDOW) begin
            r.tgt    = TGT_PRG_RAM;
            r.offset = {5'd0, acc.addr[12:0] & cfg_ram_mask};
            if (acc.op == OP_CPU_WRITE) begin
               r.we    = 1'b1;
               r.wdata = acc.data;
            end
         end else if (acc.addr[15]) begin
            if (acc.op == OP_CPU_READ) begin
               r.tgt    = TGT_PRG_ROM;
               r.offset = prg_offset(acc.addr);
            end else begin
               feed_loader(acc.addr, acc.data);
            end
         end
      end else if (acc.addr[15:13] == CHR_WINDOW) begin
         if (!ctrl_mode[4]) begin
            bank = {chr_lo[4:1], acc.addr[12]};
         end else begin
            bank = acc.addr[12] ? chr_hi : chr_lo;
         end
         r.tgt    = TGT_CHR;
         r.offset = {1'b0, bank, acc.addr[11:0]};
         if (acc.op == OP_PPU_WRITE && cfg_chr_ram) begin
            r.we    = 1'b1;
            r.wdata = acc.data;
         end
      end
      return r;
   endfunction

   // driver: hold the beat until taken, otherwise advance or idle
   always @(negedge clock) begin
      bus_access_type acc;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (access_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            acc = access_queue.pop_front();
            req_tdata  <= {acc.data, acc.addr};
            req_tuser  <= acc.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on each accepted access, check each result beat
   always @(posedge clock) begin
      bus_access_type  acc;
      mapped_beat_type want;
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         acc.op   = op_type'(req_tuser);
         acc.addr = req_tdata[15:0];
         acc.data = req_tdata[23:16];
         expected_maps.push_back(map_access(acc));
         accepted_count++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_maps.size() == 0) begin
            $error("result beat with no access pending");
            error_count++;
         end else begin
            want = expected_maps.pop_front();
            if (rsp_tuser[1:0] !== want.tgt) begin
               $error("target: expected %0d, got %0d", want.tgt, rsp_tuser[1:0]);
               error_count++;
            end
            if (rsp_tdata[17:0] !== want.offset) begin
               $error("mapped_address: expected %0h, got %0h", want.offset, rsp_tdata[17:0]);
               error_count++;
            end
            if (rsp_tuser[2] !== want.we) begin
               $error("write_enable: expected %0d, got %0d", want.we, rsp_tuser[2]);
               error_count++;
            end
            if (rsp_tdata[25:18] !== want.wdata) begin
               $error("data_out: expected %0h, got %0h", want.wdata, rsp_tdata[25:18]);
               error_count++;
            end
            if (rsp_tdata[31:26] !== 6'd0) begin
               $error("tdata padding: expected 0, got %0h", rsp_tdata[31:26]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic add_access(op_type op, logic [15:0] addr, logic [7:0] data);
      bus_access_type acc;
      acc.op   = op;
      acc.addr = addr;
      acc.data = data;
      access_queue.push_back(acc);
      pushed_count++;
   endtask

   task automatic load_register(reg_sel_type sel, logic [4:0] value);
      for (int i = 0; i < 5; i++) begin
         add_access(OP_CPU_WRITE, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), value[i]});
      end
   endtask

   task automatic add_random(int count);
      int          target_count;
      logic [15:0] addr;
      logic [15:0] edges[10];
      edges = '{16'h0000, 16'h1FFF, 16'h2000, 16'h5FFF, 16'h6000,
                16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
      target_count = pushed_count + count;
      while (pushed_count < target_count) begin
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(7) == 0) begin
               add_access(OP_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
            end
            load_register(reg_sel_type'($urandom_range(3)), 5'($urandom));
         end else begin
            case ($urandom_range(4))
               0: addr = 16'($urandom);
               1: addr = {RAM_WINDOW, 13'($urandom)};
               2: addr = {1'b1, 15'($urandom)};
               3: addr = {CHR_WINDOW, 13'($urandom)};
               default: addr = edges[$urandom_range(9)];
            endcase
            add_access(op_type'($urandom_range(3)), addr, 8'($urandom));
         end
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (accepted_count != pushed_count || expected_maps.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_PRG_ROM_BANKS: cfg_prg_banks = value[4:0];
         CSR_PRG_RAM_MASK:  cfg_ram_mask  = value[12:0];
         default:           cfg_chr_ram   = value[0];
      endcase
   endtask

   task automatic set_config(logic [4:0] banks, logic [12:0] mask, logic chr_ram);
      write_csr(CSR_PRG_ROM_BANKS, {27'd0, banks});
      write_csr(CSR_PRG_RAM_MASK, {19'd0, mask});
      write_csr(CSR_CHR_IS_RAM, {31'd0, chr_ram});
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_access(OP_CPU_READ,  16'h0000, 8'h00);
      add_access(OP_CPU_READ,  16'h5FFF, 8'hAA);
      add_access(OP_CPU_WRITE, 16'h5FFF, 8'hFF);
      add_access(OP_CPU_READ,  16'h6000, 8'h00);
      add_access(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
      add_access(OP_CPU_WRITE, 16'h6000, 8'h00);
      add_access(OP_CPU_READ,  16'h8000, 8'h00);
      add_access(OP_CPU_READ,  16'hBFFF, 8'h00);
      add_access(OP_CPU_READ,  16'hC000, 8'h00);
      add_access(OP_CPU_READ,  16'hFFFF, 8'hFF);
      add_access(OP_PPU_READ,  16'h0000, 8'h00);
      add_access(OP_PPU_WRITE, 16'h1FFF, 8'hA5);
      add_access(OP_PPU_READ,  16'h2000, 8'h00);
      add_access(OP_PPU_WRITE, 16'hFFFF, 8'h5A);
      add_access(OP_CPU_WRITE, 16'h8000, 8'h80);
      load_register(SEL_CONTROL, 5'b10110);
      add_access(OP_CPU_READ,  16'hFFFF, 8'h00);
      add_access(OP_PPU_READ,  16'h1000, 8'h00);
      add_access(OP_CPU_WRITE, 16'hE000, 8'h01);
      add_access(OP_CPU_WRITE, 16'hFFFF, 8'h7F);
      add_access(OP_CPU_WRITE, 16'hA000, 8'hFF);
      add_access(OP_CPU_READ,  16'hC000, 8'h00);
      drain();

      set_config(5'd1, 13'd0, 1'b1);
      add_random(SEGMENT_LEN);
      drain();

      set_config(5'd16, 13'h1FFF, 1'b0);
      add_random(SEGMENT_LEN);
      drain();

      send_idle_pct  = 77;
      recv_stall_pct = 21;
      set_config(5'd8, 13'h07FF, 1'b1);
      add_random(SEGMENT_LEN);
      drain();

      set_config(5'd1 << $urandom_range(4), 13'($urandom), 1'($urandom));
      add_random(SEGMENT_LEN);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_config(5'd4, 13'h0FFF, 1'b1);
      add_random(SEGMENT_LEN);
      drain();

      if (error_count == 0 && expected_maps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
